/* hdl/utf8_lenient_decoder_defines.svh */
// ---------------------------------------------------------------------------
// utf8_lenient_decoder assertion macros
// Shared assertion forms, clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef UTF8_LENIENT_DECODER_DEFINES_SVH
`define UTF8_LENIENT_DECODER_DEFINES_SVH

// same-cycle implication
`define CHK_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* hdl/utf8d_pkg.sv */
// ---------------------------------------------------------------------------
// utf8d_pkg
// Types, phase codes and constants shared by the UTF-8 decoder files.
// ---------------------------------------------------------------------------
`default_nettype none

package utf8d_pkg;

  localparam int unsigned CODE_LIMIT_DEF = 1114111;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_COLLECT = 2'd1;
  localparam logic [1:0] PH_SKIP    = 2'd2;

  typedef struct packed {
    logic [20:0] code_point;
    logic        bad_char;
    logic        end_of_text;
    logic        last_result;
  } result_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [2:0]  remaining_cont;
    logic [2:0]  total_cont;
    logic [30:0] accumulator;
  } dec_state_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } step_out_t;

  // smallest value that needs t continuation bytes
  function automatic logic [30:0] min_value(input logic [2:0] t);
    logic [30:0] v;
    case (t)
      3'd0:    v = 31'h0;
      3'd1:    v = 31'h80;
      3'd2:    v = 31'h800;
      3'd3:    v = 31'h10000;
      3'd4:    v = 31'h200000;
      default: v = 31'h4000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* hdl/utf8d_step.sv */
// ---------------------------------------------------------------------------
// utf8d_step
// Next-state and result logic for one byte: up to two result words.
// ---------------------------------------------------------------------------
`default_nettype none

module utf8d_step
  import utf8d_pkg::*;
#(
  parameter int unsigned CODE_LIMIT = CODE_LIMIT_DEF
) (
  input  dec_state_t cur,
  input  logic [7:0] byte_in,
  input  logic       allow_overlong,
  output dec_state_t nxt,
  output step_out_t  res
);

  localparam logic [30:0] LIMIT31 = 31'(CODE_LIMIT);

  typedef struct packed {
    dec_state_t st;
    logic       emit;
    result_t    r;
  } fresh_t;

  function automatic fresh_t fresh(input dec_state_t s, input logic [7:0] b);
    fresh_t     f;
    logic [2:0] n;
    f = '0;
    f.st = s;
    f.emit = 1'b1;
    f.r.last_result = 1'b1;
    n = 3'd0;
    if (b == 8'h00) begin
      f.st.phase = PH_IDLE;
      f.r.end_of_text = 1'b1;
    end else if (!b[7]) begin
      f.st.phase = PH_IDLE;
      f.r.code_point = {14'd0, b[6:0]};
    end else begin
      if (b[7:5] == 3'b110) begin
        n = 3'd1;
      end else if (b[7:4] == 4'b1110) begin
        n = 3'd2;
      end else if (b[7:3] == 5'b11110) begin
        n = 3'd3;
      end else if (b[7:2] == 6'b111110) begin
        n = 3'd4;
      end else if (b[7:1] == 7'b1111110) begin
        n = 3'd5;
      end
      if (n == 3'd0) begin
        f.st.phase = PH_SKIP;
        f.r.bad_char = 1'b1;
      end else begin
        f.emit = 1'b0;
        f.st.phase = PH_COLLECT;
        f.st.remaining_cont = n;
        f.st.total_cont = n;
        f.st.accumulator = {23'd0, b & (8'hFF >> (n + 3'd2))};
      end
    end
    return f;
  endfunction

  fresh_t      fr;
  logic [30:0] acc_new;
  logic [2:0]  rem_new;
  logic [2:0]  t;
  logic        bad;

  always_comb begin
    fr = fresh(cur, byte_in);
    acc_new = {cur.accumulator[24:0], byte_in[5:0]};
    rem_new = (cur.remaining_cont != 3'd0) ? cur.remaining_cont - 3'd1 : 3'd0;
    t = (cur.total_cont > 3'd5) ? 3'd5 : cur.total_cont;
    bad = (acc_new > LIMIT31) || ((acc_new < min_value(t)) && !allow_overlong);
    nxt = cur;
    res = '0;
    unique case (cur.phase)
      PH_COLLECT: begin
        if (byte_in[7:6] == 2'b10) begin
          nxt.accumulator = acc_new;
          nxt.remaining_cont = rem_new;
          if (rem_new == 3'd0) begin
            nxt.phase = PH_IDLE;
            res.count = 2'd1;
            res.first.last_result = 1'b1;
            if (bad) begin
              res.first.bad_char = 1'b1;
            end else begin
              res.first.code_point = acc_new[20:0];
            end
          end
        end else if (byte_in[7]) begin
          nxt.remaining_cont = 3'd0;
          nxt.phase = PH_SKIP;
          res.count = 2'd1;
          res.first.bad_char = 1'b1;
          res.first.last_result = 1'b1;
        end else begin
          // truncated sequence, then the byte itself
          nxt = fr.st;
          nxt.remaining_cont = 3'd0;
          res.count = 2'd2;
          res.first.bad_char = 1'b1;
          res.second = fr.r;
        end
      end
      PH_SKIP: begin
        if (!byte_in[7]) begin
          nxt = fr.st;
          res.count = {1'b0, fr.emit};
          res.first = fr.r;
        end
      end
      default: begin
        nxt = fr.st;
        res.count = {1'b0, fr.emit};
        res.first = fr.r;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/utf8d_outq.sv */
// ---------------------------------------------------------------------------
// utf8d_outq
// Four-entry result queue: per cycle up to two in, one out unless stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module utf8d_outq
  import utf8d_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push_en,
  input  step_out_t push,
  output logic      room,
  output logic      out_valid,
  input  logic      out_stall,
  output result_t   out_word
);

  localparam int DEPTH = 4;
  localparam int AW = $clog2(DEPTH);

  result_t       slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   level;
  logic [1:0]    n_push;
  logic          pop;
  logic [AW-1:0] wr_ptr_p1;

  assign n_push    = push_en ? push.count : 2'd0;
  assign out_valid = (level != '0);
  assign pop       = out_valid && !out_stall;
  assign room      = (level <= (AW + 1)'(DEPTH - 2));
  assign out_word  = slots[rd_ptr];
  assign wr_ptr_p1 = wr_ptr + AW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(n_push);
      rd_ptr <= rd_ptr + AW'(pop);
      level  <= level + (AW + 1)'(n_push) - (AW + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      slots[wr_ptr] <= push.first;
    end
    if (n_push == 2'd2) begin
      slots[wr_ptr_p1] <= push.second;
    end
  end

endmodule

`default_nettype wire

/* hdl/utf8_lenient_decoder.sv */
// ---------------------------------------------------------------------------
// utf8_lenient_decoder: byte-serial RFC2279 UTF-8 decoder, one to six bytes
// An input register, then the result queue; one byte accepted per cycle
// unless in_stall; one word per cycle leaves the queue port unless out_stall.
// Sync reset: idle phase, counters and allow_overlong cleared, queue empty.
// ---------------------------------------------------------------------------
`default_nettype none

module utf8_lenient_decoder
  import utf8d_pkg::*;
#(
  parameter int unsigned CODE_LIMIT = CODE_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [20:0] code_point,
  output logic        bad_char,
  output logic        end_of_text,
  output logic        last_result
);

  logic       in_full;
  logic [7:0] in_byte;
  logic       allow_overlong;
  dec_state_t state;
  dec_state_t state_next;
  step_out_t  step_res;
  logic       q_room;
  logic       advance;
  result_t    out_word;

  assign advance  = in_full && q_room;
  assign in_stall = in_full && !q_room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full        <= 1'b0;
      allow_overlong <= 1'b0;
      state          <= '{phase: PH_IDLE, default: '0};
    end else begin
      if (cfg_wr_en) begin
        allow_overlong <= cfg_wr_data;
      end
      if (in_valid && !in_stall) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= byte_in;
    end
  end

  utf8d_step #(
    .CODE_LIMIT(CODE_LIMIT)
  ) u_step (
    .cur           (state),
    .byte_in       (in_byte),
    .allow_overlong(allow_overlong),
    .nxt           (state_next),
    .res           (step_res)
  );

  utf8d_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push_en  (advance),
    .push     (step_res),
    .room     (q_room),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  assign code_point  = out_word.code_point;
  assign bad_char    = out_word.bad_char;
  assign end_of_text = out_word.end_of_text;
  assign last_result = out_word.last_result;

endmodule

`default_nettype wire

/* hdl/utf8d_checker.sv */
// ---------------------------------------------------------------------------
// utf8d_checker
// Port-level checks on the decoder result stream, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "utf8_lenient_decoder_defines.svh"

module utf8d_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [20:0] code_point,
  input wire logic        bad_char,
  input wire logic        end_of_text,
  input wire logic        last_result
);

  `CHK_NOW(a_flag_zero_cp, out_valid && (bad_char || end_of_text),
           code_point == 21'd0, "cp not zero")
  `CHK_NOW(a_flags_excl, out_valid, !(bad_char && end_of_text), "bad and end together")
  `CHK_NOW(a_end_is_last, out_valid && end_of_text, last_result, "end word not last")
  `CHK_NOW(a_lead_word_bad, out_valid && !last_result, bad_char, "leading word not bad")
  `CHK_NEXT(a_hold, out_valid && out_stall,
            out_valid && $stable(code_point) && $stable(bad_char) &&
            $stable(end_of_text) && $stable(last_result), "stalled word changed")

endmodule

bind utf8_lenient_decoder utf8d_checker u_chk (.*);

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: testbench for utf8_lenient_decoder
// Feeds directed and random byte streams (well-formed, overlong, too large,
// truncated and noise) under both overlong settings, with bursty input and
// random output stalls, and checks each decoded word in order against a
// behavioral decoder.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import utf8d_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [30:0] CODE_MAX = 31'(CODE_LIMIT_DEF);

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  byte_in = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [20:0] code_point;
  logic        bad_char;
  logic        end_of_text;
  logic        last_result;

  // decoder state of the predictor
  logic [1:0]  dec_phase = PH_IDLE;
  logic [2:0]  dec_left = 3'd0;
  logic [2:0]  dec_total = 3'd0;
  logic [30:0] dec_acc = 31'd0;
  logic        allow_ovl = 1'b0;

  result_t     want_chars[$];
  result_t     oldest_char;
  logic [7:0]  byte_queue[$];
  int unsigned fail_count = 0;
  int unsigned cycle_cnt = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stretch_left = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_cnt = 0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;

  always #5 clk = ~clk;

  utf8_lenient_decoder i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .byte_in     (byte_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code_point  (code_point),
    .bad_char    (bad_char),
    .end_of_text (end_of_text),
    .last_result (last_result)
  );

  function automatic logic [30:0] min_code(input int t);
    if (t <= 0) begin
      return 31'd0;
    end
    if (t == 1) begin
      return 31'h80;
    end
    return 31'd1 << (5 * t + 1);
  endfunction

  function automatic int char_bits(input int n);
    return (n == 0) ? 7 : 5 * n + 6;
  endfunction

  task automatic push_result(input logic [20:0] cp, input logic bad, input logic eot,
                             input logic last);
    result_t r;
    r.code_point  = cp;
    r.bad_char    = bad;
    r.end_of_text = eot;
    r.last_result = last;
    want_chars.push_back(r);
  endtask

  task automatic start_char(input logic [7:0] b);
    int ones;
    ones = 0;
    while (ones < 8 && b[7 - ones]) ones++;
    dec_phase = PH_IDLE;
    if (b == 8'h00) begin
      push_result(21'd0, 1'b0, 1'b1, 1'b1);
    end else if (!b[7]) begin
      push_result({14'd0, b[6:0]}, 1'b0, 1'b0, 1'b1);
    end else if (ones < 2 || ones > 6) begin
      dec_phase = PH_SKIP;
      push_result(21'd0, 1'b1, 1'b0, 1'b1);
    end else begin
      dec_total = 3'(ones - 1);
      dec_left  = 3'(ones - 1);
      dec_acc   = {23'd0, b & (8'hff >> (ones + 1))};
      dec_phase = PH_COLLECT;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    if (dec_phase == PH_SKIP) begin
      if (!b[7]) start_char(b);
    end else if (dec_phase != PH_COLLECT) begin
      start_char(b);
    end else if (b[7:6] == 2'b10) begin
      dec_acc = {dec_acc[24:0], b[5:0]};
      if (dec_left != 3'd0) dec_left = dec_left - 3'd1;
      if (dec_left == 3'd0) begin
        dec_phase = PH_IDLE;
        if (dec_acc > CODE_MAX || (dec_acc < min_code(int'(dec_total)) && !allow_ovl)) begin
          push_result(21'd0, 1'b1, 1'b0, 1'b1);
        end else begin
          push_result(dec_acc[20:0], 1'b0, 1'b0, 1'b1);
        end
      end
    end else begin
      dec_left = 3'd0;
      if (b[7]) begin
        dec_phase = PH_SKIP;
        push_result(21'd0, 1'b1, 1'b0, 1'b1);
      end else begin
        // broken sequence: bad word, then the byte's own word
        push_result(21'd0, 1'b1, 1'b0, 1'b0);
        start_char(b);
      end
    end
  endtask

  // n continuation bytes; v is cut to the payload bits of the form
  task automatic add_char(input int n, input logic [30:0] v);
    logic [7:0]  prefix;
    logic [30:0] val;
    val    = v & 31'((64'd1 << char_bits(n)) - 1);
    prefix = (n == 0) ? 8'h00 : 8'(8'hff << (7 - n));
    byte_queue.push_back(prefix | 8'(val >> (6 * n)));
    for (int i = n - 1; i >= 0; i--) begin
      byte_queue.push_back(8'h80 | 8'((val >> (6 * i)) & 31'h3f));
    end
  endtask

  task automatic gen_random(input int count);
    int          k;
    int          n;
    int          mode;
    logic [30:0] lo;
    logic [30:0] hi;
    k = 0;
    while (k < count) begin
      mode = $urandom_range(99, 0);
      if (mode < 55) begin
        n  = $urandom_range(3, 0);
        hi = (n == 3) ? CODE_MAX : 31'((64'd1 << char_bits(n)) - 1);
        lo = (n == 0) ? 31'd1 : min_code(n);
        add_char(n, 31'($urandom_range(hi, lo)));
        k += n + 1;
      end else if (mode < 70) begin
        n = $urandom_range(5, 1);
        add_char(n, 31'($urandom));
        k += n + 1;
      end else if (mode < 78) begin
        n = $urandom_range(5, 1);
        add_char(n, 31'($urandom_range(min_code(n) - 1, 0)));
        k += n + 1;
      end else if (mode < 86) begin
        n = $urandom_range(5, 1);
        add_char(n, 31'($urandom));
        repeat ($urandom_range(n, 1)) void'(byte_queue.pop_back());
        if ($urandom_range(1, 0) == 0) begin
          byte_queue.push_back(8'($urandom_range(127, 0)));
        end else begin
          byte_queue.push_back(8'($urandom_range(255, 128)));
        end
        k += 2;
      end else if (mode < 97) begin
        byte_queue.push_back(8'($urandom_range(255, 0)));
        k += 1;
      end else begin
        byte_queue.push_back(8'h00);
        k += 1;
      end
    end
  endtask

  task automatic set_allow(input logic v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    allow_ovl = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // checked mid-cycle so the driver's edge updates have settled
  task automatic wait_idle();
    @(negedge clk);
    while (byte_queue.size() != 0 || in_valid || want_chars.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  // driver: bursts with random gaps, payload held while stalled
  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && !in_stall) decode_byte(byte_in);
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (byte_queue.size() != 0) begin
        in_valid <= 1'b1;
        byte_in  <= byte_queue.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(60, 1);
          gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt + 1;
      if (hold_cnt == 399) hold_done <= 1'b1;
    end else begin
      if (stretch_left == 0) begin
        stretch_left <= $urandom_range(60, 1);
        case ($urandom_range(2, 0))
          0:       stall_pct <= 0;
          1:       stall_pct <= 30;
          default: stall_pct <= 80;
        endcase
      end else begin
        stretch_left <= stretch_left - 1;
      end
      out_stall <= ($urandom_range(99, 0) < stall_pct);
    end
  end

  // monitor: in-order compare of each accepted word
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (want_chars.size() == 0) begin
        $error("unexpected word: code_point %0h bad %0b end %0b last %0b",
               code_point, bad_char, end_of_text, last_result);
        fail_count++;
      end else begin
        oldest_char = want_chars.pop_front();
        if (code_point !== oldest_char.code_point) begin
          $error("code_point: expected %0h, got %0h", oldest_char.code_point, code_point);
          fail_count++;
        end
        if (bad_char !== oldest_char.bad_char) begin
          $error("bad_char: expected %0b, got %0b", oldest_char.bad_char, bad_char);
          fail_count++;
        end
        if (end_of_text !== oldest_char.end_of_text) begin
          $error("end_of_text: expected %0b, got %0b", oldest_char.end_of_text, end_of_text);
          fail_count++;
        end
        if (last_result !== oldest_char.last_result) begin
          $error("last_result: expected %0b, got %0b", oldest_char.last_result, last_result);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    set_allow(1'b0);
    add_char(0, 31'h0);
    add_char(0, 31'h7f);
    add_char(1, 31'he9);
    add_char(2, 31'h20ac);
    add_char(3, 31'h10ffff);
    add_char(3, 31'h110000);
    add_char(1, 31'h0);
    // invalid lead, then skipped high bytes until ASCII
    byte_queue.push_back(8'h80);
    byte_queue.push_back(8'hfe);
    byte_queue.push_back(8'hff);
    byte_queue.push_back(8'h41);
    // missing continuation: high byte, nul, ASCII
    byte_queue.push_back(8'hc3);
    byte_queue.push_back(8'he2);
    byte_queue.push_back(8'h41);
    byte_queue.push_back(8'hc3);
    byte_queue.push_back(8'h00);
    byte_queue.push_back(8'he2);
    byte_queue.push_back(8'h82);
    byte_queue.push_back(8'h41);
    gen_random(300);
    wait_idle();

    set_allow(1'b1);
    add_char(1, 31'h0);
    add_char(5, 31'h0);
    add_char(4, 31'h1fffff);
    gen_random(300);
    hold_req <= 1'b1;
    wait_idle();

    set_allow(1'b0);
    gen_random(200);
    wait_idle();

    set_allow(1'b1);
    gen_random(200);
    wait_idle();

    if (fail_count == 0 && want_chars.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
